FILE: hw/rtl/cft_pkg.sv
`default_nettype none

package cft_pkg;

    // A token holds at most MaxTokenLen-1 bytes.
    localparam int MaxTokenLen = 200;
    localparam logic [7:0] TokenLimit = 8'(MaxTokenLen - 1);

    localparam int QueueDepth = 4;
    localparam int QueueAddrW = $clog2(QueueDepth);
    localparam int QueueCountW = $clog2(QueueDepth + 1);

    localparam logic [30:0] IntMax = 31'h7FFF_FFFF;
    localparam logic [15:0] LineMax = 16'hFFFF;

    localparam logic [7:0] CharCmd = 8'h3E;
    localparam logic [7:0] CharUnderscore = 8'h5F;
    localparam logic [7:0] CharNewline = 8'h0A;

    typedef enum logic [3:0] {
        KIND_TEXT = 4'd0,
        KIND_COMMAND = 4'd1,
        KIND_INTEGER = 4'd2,
        KIND_IDENT = 4'd3,
        KIND_MODE = 4'd4,
        KIND_INIT = 4'd5,
        KIND_SINGLE = 4'd6,
        KIND_END = 4'd7,
        KIND_ERROR = 4'd8
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE = 2'd0,
        ERR_TOO_LONG = 2'd1,
        ERR_EOF_IN_CMD = 2'd2
    } err_t;

    typedef struct packed {
        logic [7:0] char_in;
        logic end_of_input;
    } char_word_t;

    typedef struct packed {
        kind_t kind;
        logic [7:0] text_byte;
        logic [30:0] int_value;
        err_t error_code;
        logic [15:0] line_number;
        logic last;
    } token_word_t;

    // Up to two results written into the output queue in one cycle.
    typedef struct packed {
        logic [1:0] n;
        token_word_t r0;
        token_word_t r1;
    } push_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) ? c + 8'd32 : c;
    endfunction

    function automatic logic [7:0] mode_char(input logic [1:0] idx);
        logic [7:0] ch;
        unique case (idx)
            2'd0: ch = 8'h6D;
            2'd1: ch = 8'h6F;
            2'd2: ch = 8'h64;
            default: ch = 8'h65;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] init_char(input logic [3:0] idx);
        logic [7:0] ch;
        unique case (idx)
            4'd0: ch = 8'h69;
            4'd1: ch = 8'h6E;
            4'd2: ch = 8'h69;
            4'd3: ch = 8'h74;
            4'd4: ch = 8'h69;
            4'd5: ch = 8'h61;
            4'd6: ch = 8'h6C;
            4'd7: ch = 8'h69;
            4'd8: ch = 8'h7A;
            4'd9: ch = 8'h65;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/cft_lexer.sv
`default_nettype none

module cft_lexer
    import cft_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       accept,
    input  wire char_word_t word,
    output push_t           push
);

    typedef enum logic [4:0] {
        LEX_IDLE = 5'b00001,
        LEX_CMD_LEAD = 5'b00010,
        LEX_CMD_BODY = 5'b00100,
        LEX_INT = 5'b01000,
        LEX_IDENT = 5'b10000
    } lex_mode_t;

    lex_mode_t mode_reg, mode_next;
    logic [7:0] len_reg, len_next;
    logic [30:0] acc_reg, acc_next;
    logic [1:0] kw_reg, kw_next;
    logic [15:0] line_reg, line_next;
    logic halted_reg, halted_next;

    logic [7:0] c;
    logic eof;
    logic [3:0] digit;
    logic [34:0] acc_prod;
    logic [30:0] acc_step;

    assign c = word.char_in;
    assign eof = word.end_of_input;
    assign digit = 4'(c - 8'h30);
    assign acc_prod = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0} + {31'd0, digit};
    assign acc_step = (acc_prod > {4'd0, IntMax}) ? IntMax : acc_prod[30:0];

    always_comb
    begin
        token_word_t close_r;
        token_word_t prim_r;
        logic have_close;
        logic have_prim;
        logic run_idle;
        logic do_append;
        logic do_kw;
        logic [7:0] base_len;
        logic [7:0] lc;
        logic [1:0] kw_base;

        close_r = '0;
        prim_r = '0;
        have_close = 1'b0;
        have_prim = 1'b0;
        run_idle = 1'b0;
        do_append = 1'b0;
        do_kw = 1'b0;
        base_len = len_reg;
        lc = to_lower(c);
        kw_base = kw_reg;

        mode_next = mode_reg;
        len_next = len_reg;
        acc_next = acc_reg;
        kw_next = kw_reg;
        halted_next = halted_reg;
        line_next = line_reg;

        if (!eof && c == CharNewline && line_reg != LineMax)
        begin
            line_next = line_reg + 16'd1;
        end

        unique case (mode_reg)
            LEX_CMD_LEAD, LEX_CMD_BODY:
            begin
                if (eof)
                begin
                    have_prim = 1'b1;
                    prim_r.kind = KIND_ERROR;
                    prim_r.error_code = ERR_EOF_IN_CMD;
                    halted_next = 1'b1;
                    mode_next = LEX_IDLE;
                end
                else if (c == CharNewline)
                begin
                    have_prim = 1'b1;
                    prim_r.kind = KIND_COMMAND;
                    mode_next = LEX_IDLE;
                end
                else if (!(mode_reg == LEX_CMD_LEAD && is_space(c)))
                begin
                    mode_next = LEX_CMD_BODY;
                    do_append = 1'b1;
                end
            end
            LEX_INT:
            begin
                if (!eof && is_digit(c))
                begin
                    acc_next = acc_step;
                    do_append = 1'b1;
                end
                else
                begin
                    have_close = 1'b1;
                    close_r.kind = KIND_INTEGER;
                    close_r.int_value = acc_reg;
                    mode_next = LEX_IDLE;
                    run_idle = 1'b1;
                end
            end
            LEX_IDENT:
            begin
                if (!eof && (is_alpha(c) || is_digit(c) || c == CharUnderscore))
                begin
                    do_kw = 1'b1;
                    do_append = 1'b1;
                end
                else
                begin
                    have_close = 1'b1;
                    if (kw_reg[0] && len_reg == 8'd4)
                    begin
                        close_r.kind = KIND_MODE;
                    end
                    else if (kw_reg[1] && len_reg == 8'd10)
                    begin
                        close_r.kind = KIND_INIT;
                    end
                    else
                    begin
                        close_r.kind = KIND_IDENT;
                    end
                    mode_next = LEX_IDLE;
                    run_idle = 1'b1;
                end
            end
            default:
            begin
                mode_next = LEX_IDLE;
                run_idle = 1'b1;
            end
        endcase

        // Idle lexing also runs on the character that closed a token.
        if (run_idle)
        begin
            base_len = 8'd0;
            priority if (eof)
            begin
                have_prim = 1'b1;
                prim_r.kind = KIND_END;
            end
            else if (is_space(c))
            begin
                have_prim = 1'b0;
            end
            else if (c == CharCmd)
            begin
                mode_next = LEX_CMD_LEAD;
                len_next = 8'd0;
            end
            else if (is_digit(c))
            begin
                mode_next = LEX_INT;
                acc_next = {27'd0, digit};
                do_append = 1'b1;
            end
            else if (is_alpha(c) || c == CharUnderscore)
            begin
                mode_next = LEX_IDENT;
                kw_base = 2'b11;
                kw_next = 2'b11;
                do_kw = 1'b1;
                do_append = 1'b1;
            end
            else
            begin
                have_prim = 1'b1;
                prim_r.kind = KIND_SINGLE;
                prim_r.text_byte = c;
            end
        end

        if (do_kw)
        begin
            kw_next = kw_base;
            if (!(base_len < 8'd4 && lc == mode_char(base_len[1:0])))
            begin
                kw_next[0] = 1'b0;
            end
            if (!(base_len < 8'd10 && lc == init_char(base_len[3:0])))
            begin
                kw_next[1] = 1'b0;
            end
        end

        if (do_append)
        begin
            have_prim = 1'b1;
            if (base_len >= TokenLimit)
            begin
                prim_r.kind = KIND_ERROR;
                prim_r.error_code = ERR_TOO_LONG;
                halted_next = 1'b1;
                mode_next = LEX_IDLE;
            end
            else
            begin
                len_next = base_len + 8'd1;
                prim_r.kind = KIND_TEXT;
                prim_r.text_byte = c;
            end
        end

        close_r.line_number = line_next;
        prim_r.line_number = line_next;

        push = '0;
        if (accept && !halted_reg)
        begin
            if (have_close)
            begin
                push.r0 = close_r;
                push.r1 = prim_r;
                push.n = have_prim ? 2'd2 : 2'd1;
                push.r0.last = !have_prim;
                push.r1.last = have_prim;
            end
            else if (have_prim)
            begin
                push.r0 = prim_r;
                push.r0.last = 1'b1;
                push.n = 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= LEX_IDLE;
            len_reg <= '0;
            acc_reg <= '0;
            kw_reg <= 2'b11;
            line_reg <= 16'd1;
            halted_reg <= 1'b0;
        end
        else if (accept && !halted_reg)
        begin
            mode_reg <= mode_next;
            len_reg <= len_next;
            acc_reg <= acc_next;
            kw_reg <= kw_next;
            line_reg <= line_next;
            halted_reg <= halted_next;
        end
    end

    a_halted_silent: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |-> push.n == 2'd0)
        else $error("lexer produced a result while halted");

    a_error_halts: assert property (@(posedge clk) disable iff (!rst_n)
        (push.n == 2'd1 && push.r0.kind == KIND_ERROR) |=> halted_reg)
        else $error("error result did not halt the lexer");

    a_pair_last: assert property (@(posedge clk) disable iff (!rst_n)
        push.n == 2'd2 |-> (push.r1.last && !push.r0.last))
        else $error("last flag misplaced on a result pair");

    a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        line_reg != 16'd0)
        else $error("line count reached zero");

endmodule

`default_nettype wire

FILE: hw/rtl/cft_queue.sv
`default_nettype none

module cft_queue
    import cft_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire push_t   push,
    output logic         full,
    output logic         token_valid,
    input  wire logic    token_stall,
    output token_word_t  token_word
);

    token_word_t mem [QueueDepth];
    logic [QueueAddrW-1:0] head_reg, head_next;
    logic [QueueAddrW-1:0] tail_reg, tail_next;
    logic [QueueCountW-1:0] count_reg, count_next;
    logic pop;

    // Room for the largest burst one character can cause.
    assign full = count_reg > QueueCountW'(QueueDepth - 2);
    assign token_valid = count_reg != '0;
    assign token_word = mem[head_reg];
    assign pop = token_valid && !token_stall;

    always_comb
    begin
        head_next = head_reg + QueueAddrW'(pop);
        tail_next = tail_reg + QueueAddrW'(push.n);
        count_next = count_reg + QueueCountW'(push.n) - QueueCountW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.n != 2'd0)
        begin
            mem[tail_reg] <= push.r0;
        end
        if (push.n == 2'd2)
        begin
            mem[tail_reg + QueueAddrW'(1)] <= push.r1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QueueCountW'(QueueDepth))
        else $error("output queue overflow");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> push.n == 2'd0)
        else $error("result written while queue full");

    a_stalled_word_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (token_valid && token_stall) |=> (token_valid && $stable(token_word)))
        else $error("stalled token word changed");

endmodule

`default_nettype wire

FILE: hw/rtl/command_file_tokenizer.sv
// Command file tokenizer.
// The char channel (char_valid, char_stall, char_word) takes one character
// word per cycle, or an end-of-input mark. The token channel (token_valid,
// token_stall, token_word) gives token text bytes, one per word, followed by
// an end word carrying the token kind, plus single-character, end-of-input
// and error words. The word with last set closes the results of one input.
// Throughput: one character per cycle while the four-entry output queue has
// room for two words; characters that close a token and start another make
// two words, which drain at one word per cycle while the receiver does not
// stall. When the receiver stalls, the queue holds its words unchanged and
// char_stall rises once fewer than two entries are free.
// Reset empties the queue, sets the lexer idle with the line count at one
// and clears the halt. After a token-too-long or end-inside-command error
// the block keeps accepting characters but gives no words until reset.
`default_nettype none

module command_file_tokenizer
    import cft_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       char_valid,
    output logic            char_stall,
    input  wire char_word_t char_word,
    output logic            token_valid,
    input  wire logic       token_stall,
    output token_word_t     token_word
);

    push_t push;
    logic accept;

    assign accept = char_valid && !char_stall;

    cft_lexer u_lexer (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .word   (char_word),
        .push   (push)
    );

    cft_queue u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (char_stall),
        .token_valid (token_valid),
        .token_stall (token_stall),
        .token_word  (token_word)
    );

endmodule

`default_nettype wire

FILE: tb/tb_command_file_tokenizer.sv
module tb_command_file_tokenizer;
    timeunit 1ns;
    timeprecision 1ps;

    import cft_pkg::*;

    localparam int CycleLimit = 20_000;
    localparam int DrainCycles = 16;
    localparam logic [8*4-1:0] KwMode = "mode";
    localparam logic [8*10-1:0] KwInit = "initialize";

    typedef enum logic [2:0] {
        LEX_IDLE,
        LEX_CMD_LEAD,
        LEX_CMD_BODY,
        LEX_INT,
        LEX_IDENT
    } lex_state_t;

    typedef struct {
        logic [7:0] ch;
        logic eof;
        logic typed;
        kind_t kind;
        logic [7:0] text;
        err_t err;
        logic [15:0] line;
    } stim_row_t;

    logic clk;
    logic rst_n = 1'b0;
    logic char_valid = 1'b0;
    logic char_stall;
    char_word_t char_word = '0;
    logic token_valid;
    logic token_stall = 1'b0;
    token_word_t token_word;

    // Lexer state as the token stream predicts it.
    lex_state_t lex = LEX_IDLE;
    int tok_len = 0;
    logic [30:0] int_acc = '0;
    logic [1:0] kw_live = 2'b11;
    logic [15:0] line_cnt = 16'd1;
    logic dead = 1'b0;

    token_word_t words_due[$];
    int results_caused = 0;
    int errors = 0;
    int cycles = 0;
    int gap_pct = 12;
    int hold_pct = 76;

    // Directed opening: rows with a typed expectation cause exactly one word.
    stim_row_t script [0:24] = '{
        '{8'h21, 1'b0, 1'b1, KIND_SINGLE, 8'h21, ERR_NONE, 16'd1},
        '{8'h00, 1'b0, 1'b1, KIND_SINGLE, 8'h00, ERR_NONE, 16'd1},
        '{8'hFF, 1'b0, 1'b1, KIND_SINGLE, 8'hFF, ERR_NONE, 16'd1},
        // The character that comes with an end-of-input mark is ignored.
        '{8'h3E, 1'b1, 1'b1, KIND_END, 8'h00, ERR_NONE, 16'd1},
        '{8'h0A, 1'b0, 1'b0, KIND_TEXT, 8'h00, ERR_NONE, 16'd0},
        '{"m", 1'b0, 1'b0, KIND_TEXT, 8'h00, ERR_NONE, 16'd0},
        '{"O", 1'b0, 1'b0, KIND_TEXT, 8'h00, ERR_NONE, 16'd0},
        '{"d", 1'b0, 1'b0, KIND_TEXT, 8'h00, ERR_NONE, 16'd0},
        '{"E", 1'b0, 1'b0, KIND_TEXT, 8'h00, ERR_NONE, 16'd0},
        '{8'h3E, 1'b0, 1'b1, KIND_MODE, 8'h00, ERR_NONE, 16'd2},
        '{8'h20, 1'b0, 1'b0, KIND_TEXT, 8'h00, ERR_NONE, 16'd0},
        '{8'h80, 1'b0, 1'b0, KIND_TEXT, 8'h00, ERR_NONE, 16'd0},
        '{8'h0A, 1'b0, 1'b1, KIND_COMMAND, 8'h00, ERR_NONE, 16'd3},
        '{"9", 1'b0, 1'b0, KIND_TEXT, 8'h00, ERR_NONE, 16'd0},
        '{"9", 1'b0, 1'b0, KIND_TEXT, 8'h00, ERR_NONE, 16'd0},
        '{"9", 1'b0, 1'b0, KIND_TEXT, 8'h00, ERR_NONE, 16'd0},
        '{"9", 1'b0, 1'b0, KIND_TEXT, 8'h00, ERR_NONE, 16'd0},
        '{"9", 1'b0, 1'b0, KIND_TEXT, 8'h00, ERR_NONE, 16'd0},
        '{"9", 1'b0, 1'b0, KIND_TEXT, 8'h00, ERR_NONE, 16'd0},
        '{"9", 1'b0, 1'b0, KIND_TEXT, 8'h00, ERR_NONE, 16'd0},
        '{"9", 1'b0, 1'b0, KIND_TEXT, 8'h00, ERR_NONE, 16'd0},
        '{"9", 1'b0, 1'b0, KIND_TEXT, 8'h00, ERR_NONE, 16'd0},
        '{"9", 1'b0, 1'b0, KIND_TEXT, 8'h00, ERR_NONE, 16'd0},
        '{"9", 1'b0, 1'b0, KIND_TEXT, 8'h00, ERR_NONE, 16'd0},
        '{8'h00, 1'b1, 1'b0, KIND_TEXT, 8'h00, ERR_NONE, 16'd0}
    };

    command_file_tokenizer dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_word  (char_word),
        .token_valid(token_valid),
        .token_stall(token_stall),
        .token_word (token_word)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic is_blank(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic is_numeral(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic token_word_t word_of(input kind_t k, input logic [7:0] b,
                                            input logic [30:0] v, input err_t e);
        token_word_t w;
        w.kind = k;
        w.text_byte = b;
        w.int_value = v;
        w.error_code = e;
        w.line_number = line_cnt;
        w.last = 1'b0;
        return w;
    endfunction

    // Adds one byte to the open token, or halts when the token is full.
    function automatic token_word_t take_byte(input logic [7:0] c);
        if (tok_len >= MaxTokenLen - 1)
        begin
            dead = 1'b1;
            lex = LEX_IDLE;
            return word_of(KIND_ERROR, 8'h00, '0, ERR_TOO_LONG);
        end
        tok_len++;
        return word_of(KIND_TEXT, c, '0, ERR_NONE);
    endfunction

    function automatic void match_keywords(input logic [7:0] c);
        logic [7:0] lc;
        lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
        if (tok_len < 4)
        begin
            if (lc != KwMode[8*(3-tok_len) +: 8])
                kw_live[0] = 1'b0;
        end
        else
            kw_live[0] = 1'b0;
        if (tok_len < 10)
        begin
            if (lc != KwInit[8*(9-tok_len) +: 8])
                kw_live[1] = 1'b0;
        end
        else
            kw_live[1] = 1'b0;
    endfunction

    function automatic int lex_from_idle(input logic [7:0] c, input logic eof,
                                         output token_word_t w);
        w = '0;
        if (eof)
        begin
            w = word_of(KIND_END, 8'h00, '0, ERR_NONE);
            return 1;
        end
        if (is_blank(c))
            return 0;
        if (c == CharCmd)
        begin
            lex = LEX_CMD_LEAD;
            tok_len = 0;
            return 0;
        end
        if (is_numeral(c))
        begin
            lex = LEX_INT;
            tok_len = 0;
            int_acc = 31'(c - 8'h30);
            w = take_byte(c);
            return 1;
        end
        if (is_letter(c) || c == CharUnderscore)
        begin
            lex = LEX_IDENT;
            tok_len = 0;
            kw_live = 2'b11;
            match_keywords(c);
            w = take_byte(c);
            return 1;
        end
        w = word_of(KIND_SINGLE, c, '0, ERR_NONE);
        return 1;
    endfunction

    // Returns how many words one input word causes, in the order they leave.
    function automatic int lex_char(input logic [7:0] c, input logic eof,
                                    output token_word_t w0, output token_word_t w1);
        int n;
        longint grown;
        kind_t k;
        n = 0;
        w0 = '0;
        w1 = '0;
        if (dead)
            return 0;
        if (!eof && c == CharNewline && line_cnt != LineMax)
            line_cnt++;
        case (lex)
            LEX_CMD_LEAD, LEX_CMD_BODY:
            begin
                if (eof)
                begin
                    w0 = word_of(KIND_ERROR, 8'h00, '0, ERR_EOF_IN_CMD);
                    dead = 1'b1;
                    lex = LEX_IDLE;
                    n = 1;
                end
                else if (c == CharNewline)
                begin
                    w0 = word_of(KIND_COMMAND, 8'h00, '0, ERR_NONE);
                    lex = LEX_IDLE;
                    n = 1;
                end
                else if (!(lex == LEX_CMD_LEAD && is_blank(c)))
                begin
                    lex = LEX_CMD_BODY;
                    w0 = take_byte(c);
                    n = 1;
                end
            end
            LEX_INT:
            begin
                if (!eof && is_numeral(c))
                begin
                    grown = longint'(int_acc) * 10 + longint'(c - 8'h30);
                    int_acc = (grown > IntMax) ? IntMax : grown[30:0];
                    w0 = take_byte(c);
                    n = 1;
                end
                else
                begin
                    w0 = word_of(KIND_INTEGER, 8'h00, int_acc, ERR_NONE);
                    lex = LEX_IDLE;
                    n = 1 + lex_from_idle(c, eof, w1);
                end
            end
            LEX_IDENT:
            begin
                if (!eof && (is_letter(c) || is_numeral(c) || c == CharUnderscore))
                begin
                    match_keywords(c);
                    w0 = take_byte(c);
                    n = 1;
                end
                else
                begin
                    k = KIND_IDENT;
                    if (kw_live[0] && tok_len == 4)
                        k = KIND_MODE;
                    else if (kw_live[1] && tok_len == 10)
                        k = KIND_INIT;
                    w0 = word_of(k, 8'h00, '0, ERR_NONE);
                    lex = LEX_IDLE;
                    n = 1 + lex_from_idle(c, eof, w1);
                end
            end
            default:
                n = lex_from_idle(c, eof, w0);
        endcase
        if (n == 1)
            w0.last = 1'b1;
        else if (n == 2)
            w1.last = 1'b1;
        return n;
    endfunction

    function automatic void check_word(input token_word_t got);
        token_word_t want;
        if (words_due.size() == 0)
        begin
            $display("%0t: token word %h arrived with none expected", $time, got);
            errors++;
            return;
        end
        want = words_due.pop_front();
        if (got.kind !== want.kind)
        begin
            $display("%0t: kind expected %0d got %0d", $time, want.kind, got.kind);
            errors++;
        end
        if (got.text_byte !== want.text_byte)
        begin
            $display("%0t: text_byte expected %h got %h", $time, want.text_byte, got.text_byte);
            errors++;
        end
        if (got.int_value !== want.int_value)
        begin
            $display("%0t: int_value expected %0d got %0d", $time, want.int_value, got.int_value);
            errors++;
        end
        if (got.error_code !== want.error_code)
        begin
            $display("%0t: error_code expected %0d got %0d", $time, want.error_code,
                     got.error_code);
            errors++;
        end
        if (got.line_number !== want.line_number)
        begin
            $display("%0t: line_number expected %0d got %0d", $time, want.line_number,
                     got.line_number);
            errors++;
        end
        if (got.last !== want.last)
        begin
            $display("%0t: last expected %b got %b", $time, want.last, got.last);
            errors++;
        end
    endfunction

    function automatic logic [7:0] ident_char();
        int r;
        r = $urandom_range(62);
        if (r < 26)
            return 8'("a" + r);
        if (r < 52)
            return 8'("A" + r - 26);
        if (r < 62)
            return 8'("0" + r - 52);
        return CharUnderscore;
    endfunction

    function automatic logic [7:0] cmd_byte();
        logic [7:0] c;
        do
            c = 8'($urandom_range(255));
        while (c == CharNewline);
        return c;
    endfunction

    // Offers one character word and returns at the edge where it is taken.
    task automatic send_char(input logic [7:0] c, input logic eof);
        while ($urandom_range(99) < gap_pct)
        begin
            char_valid <= 1'b0;
            @(posedge clk);
        end
        char_valid <= 1'b1;
        char_word <= '{char_in: c, end_of_input: eof};
        @(posedge clk);
        while (char_stall)
            @(posedge clk);
    endtask

    task automatic feed(input logic [7:0] c, input logic eof);
        token_word_t w0, w1;
        int n;
        send_char(c, eof);
        n = lex_char(c, eof, w0, w1);
        if (n > 0)
        begin
            words_due.push_back(w0);
            results_caused++;
        end
        if (n > 1)
            words_due.push_back(w1);
    endtask

    // End of input inside a command would halt the block, so close it first.
    task automatic end_input();
        if (lex == LEX_CMD_LEAD || lex == LEX_CMD_BODY)
            feed(CharNewline, 1'b0);
        feed(8'($urandom_range(255)), 1'b1);
    endtask

    task automatic close_token();
        case ($urandom_range(6))
            0: feed(8'h20, 1'b0);
            1: feed(CharNewline, 1'b0);
            2: feed(";", 1'b0);
            3: feed(8'h09, 1'b0);
            4: feed(8'($urandom_range(128, 255)), 1'b0);
            5: feed(CharCmd, 1'b0);
            default: end_input();
        endcase
    endtask

    task automatic random_segment();
        logic [7:0] c;
        logic [8*10-1:0] kw;
        int kw_len, len, i;
        // Keep any token far from the length limit; the error halts for good.
        if (lex != LEX_IDLE && tok_len > 150)
            feed(CharNewline, 1'b0);
        case ($urandom_range(11))
            0, 1, 2:
            begin
                if ($urandom_range(1))
                begin
                    kw = {48'd0, KwMode};
                    kw_len = 4;
                end
                else
                begin
                    kw = KwInit;
                    kw_len = 10;
                end
                case ($urandom_range(3))
                    0: len = kw_len - 1;
                    1: len = kw_len + 1;
                    default: len = kw_len;
                endcase
                for (i = 0; i < len; i++)
                begin
                    if (i < kw_len)
                    begin
                        c = kw[8*(kw_len-1-i) +: 8];
                        if ($urandom_range(1))
                            c = c - 8'd32;
                    end
                    else
                        c = ident_char();
                    feed(c, 1'b0);
                end
                close_token();
            end
            3, 4:
            begin
                c = ident_char();
                feed(is_numeral(c) ? CharUnderscore : c, 1'b0);
                len = $urandom_range(10);
                for (i = 0; i < len; i++)
                    feed(ident_char(), 1'b0);
                close_token();
            end
            5, 6:
            begin
                len = ($urandom_range(6) == 0) ? $urandom_range(9, 13) : $urandom_range(1, 3);
                for (i = 0; i < len; i++)
                    feed(8'("0" + $urandom_range(9)), 1'b0);
                close_token();
            end
            7, 8:
            begin
                feed(CharCmd, 1'b0);
                len = $urandom_range(3);
                for (i = 0; i < len; i++)
                    feed($urandom_range(1) ? 8'h20 : 8'h09, 1'b0);
                len = $urandom_range(20);
                for (i = 0; i < len; i++)
                    feed(cmd_byte(), 1'b0);
                feed(CharNewline, 1'b0);
            end
            9:
            begin
                len = $urandom_range(1, 3);
                for (i = 0; i < len; i++)
                    feed(($urandom_range(5) == 0) ? 8'h20 : 8'($urandom_range(9, 13)), 1'b0);
            end
            10:
                end_input();
            default:
                feed(8'($urandom_range(255)), 1'b0);
        endcase
    endtask

    task automatic random_phase(input int gap, input int hold, input int quota);
        gap_pct = gap;
        hold_pct = hold;
        results_caused = 0;
        while (results_caused < quota)
            random_segment();
    endtask

    initial
    begin
        while (cycles < CycleLimit)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("status: fail");
        $finish;
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && token_valid && !token_stall)
                check_word(token_word);
            token_stall <= ($urandom_range(99) < hold_pct);
        end
    end

    initial
    begin
        token_word_t w0, w1;
        logic [7:0] c;
        int i, len, n;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (script[i])
        begin
            send_char(script[i].ch, script[i].eof);
            n = lex_char(script[i].ch, script[i].eof, w0, w1);
            if (script[i].typed)
                words_due.push_back(token_word_t'{script[i].kind, script[i].text, 31'd0,
                                                  script[i].err, script[i].line, 1'b1});
            else
            begin
                if (n > 0)
                    words_due.push_back(w0);
                if (n > 1)
                    words_due.push_back(w1);
            end
        end

        random_phase(12, 76, 100);
        random_phase(76, 12, 100);
        random_phase(0, 0, 100);

        // One fatal error ends the useful life of the block, so it comes last.
        case ($urandom_range(3))
            0:
            begin
                feed(CharCmd, 1'b0);
                len = $urandom_range(3);
                for (i = 0; i < len; i++)
                    feed(8'h20, 1'b0);
                len = $urandom_range(5);
                for (i = 0; i < len; i++)
                    feed(cmd_byte(), 1'b0);
                feed(8'($urandom_range(255)), 1'b1);
            end
            1:
            begin
                feed(CharCmd, 1'b0);
                feed("x", 1'b0);
                for (i = 1; i < MaxTokenLen; i++)
                    feed(cmd_byte(), 1'b0);
            end
            2:
            begin
                for (i = 0; i < MaxTokenLen; i++)
                    feed(8'("0" + $urandom_range(9)), 1'b0);
            end
            default:
            begin
                feed(CharUnderscore, 1'b0);
                for (i = 1; i < MaxTokenLen; i++)
                    feed(ident_char(), 1'b0);
            end
        endcase
        // A halted block takes characters but must stay silent.
        for (i = 0; i < 8; i++)
        begin
            c = 8'($urandom_range(255));
            feed(c, i == 7);
        end
        char_valid <= 1'b0;

        while (words_due.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
